>>> src/rk4_unicycle_state_step_core_assert.svh
// Assertion macros for the RK4 unicycle step core checker.
`ifndef RK4_UNICYCLE_STATE_STEP_CORE_ASSERT_SVH
`define RK4_UNICYCLE_STATE_STEP_CORE_ASSERT_SVH

// Same-cycle implication.
`define RK4US_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rk4us check failed");

// Next-cycle implication.
`define RK4US_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rk4us check failed");

`endif

>>> src/rk4us_pkg.sv
package rk4us_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic [15:0] dt_t;

    localparam int ANG_W = 34;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam int SUM_W = 36;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam logic [63:0] TWO_PI_Q60     = 64'h6487ED5110B4611A;
    localparam ang_t        PI_Q30         = 34'sd3373259426;
    localparam ang_t        HALF_PI_Q30    = 34'sd1686629713;
    localparam ang_t        TWO_PI_Q30     = 34'sd6746518852;
    localparam ang_t        CORDIC_K_Q30   = 34'sd652032874;
    localparam logic [30:0] INV_TWO_PI_Q32 = 31'd683565275;

    localparam dt_t STEP_TIME_RST = 16'd6554;

    localparam int ATAN_N = 24;
    localparam logic signed [31:0] ATAN_Q30 [ATAN_N] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128
    };

    function automatic word_t sat_word(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        word_t r;
        hi = 48'sd2147483647;
        lo = -48'sd2147483648;
        if (v > hi)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < lo)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> src/rk4us_eval.sv
// Slope unit: angle reduction, CORDIC sin/cos, speed scaling.
module rk4us_eval #(
    parameter int FRAC_BITS  = 16,
    parameter int TRIG_STEPS = 16,
    parameter int SIDE_W     = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rk4us_pkg::word_t     in_angle,
    input  rk4us_pkg::word_t     in_speed,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output rk4us_pkg::word_t     out_kx,
    output rk4us_pkg::word_t     out_ky,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int LAT = TRIG_STEPS + 9;
    localparam int QW  = 32 - FRAC_BITS;
    localparam int PW  = 33 + FRAC_BITS;
    localparam int LW  = SIDE_W + 32;
    localparam logic [63:0] PERIOD = rk4us_pkg::TWO_PI_Q60 >> (30 - FRAC_BITS);
    localparam logic signed [63:0] PERIOD_S = PERIOD;

    logic [LAT-1:0] vld_reg;
    logic [LW-1:0]  line_reg [LAT];

    // reduction
    logic signed [63:0]   est_prod;
    logic signed [63:0]   est_reg;
    rk4us_pkg::word_t     ang1_reg;
    logic signed [QW-1:0] quo;
    logic signed [65:0]   qp_full;
    logic signed [63:0]   qp_reg;
    rk4us_pkg::word_t     ang2_reg;
    logic signed [63:0]   ang_shift;
    logic signed [63:0]   rem_reg;
    logic signed [63:0]   rem_fix;
    rk4us_pkg::ang_t      red_reg;
    rk4us_pkg::ang_t      fold_reg;

    // CORDIC
    rk4us_pkg::ang_t cx_reg [TRIG_STEPS+1];
    rk4us_pkg::ang_t cy_reg [TRIG_STEPS+1];
    rk4us_pkg::ang_t cz_reg [TRIG_STEPS+1];
    logic            neg_reg [TRIG_STEPS+1];

    // scaling
    rk4us_pkg::ang_t    cos_reg;
    rk4us_pkg::ang_t    sin_reg;
    rk4us_pkg::word_t   spd;
    logic signed [65:0] pc_reg;
    logic signed [65:0] ps_reg;
    logic signed [65:0] rnd_c;
    logic signed [65:0] rnd_s;
    rk4us_pkg::word_t   kx_reg;
    rk4us_pkg::word_t   ky_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg[0] <= {in_speed, in_side};
        for (int j = 1; j < LAT; j++)
        begin
            line_reg[j] <= line_reg[j-1];
        end
    end

    assign est_prod  = in_angle * $signed({1'b0, rk4us_pkg::INV_TWO_PI_Q32});
    assign quo       = est_reg[63 -: QW];
    assign qp_full   = quo * $signed({1'b0, PERIOD[PW-1:0]});
    assign ang_shift = {{2{ang2_reg[31]}}, ang2_reg, 30'd0};

    always_comb
    begin
        priority if (rem_reg < 0)
        begin
            rem_fix = rem_reg + PERIOD_S;
        end
        else if (rem_reg >= PERIOD_S)
        begin
            rem_fix = rem_reg - PERIOD_S;
        end
        else
        begin
            rem_fix = rem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        est_reg  <= est_prod;
        ang1_reg <= in_angle;
        qp_reg   <= qp_full[63:0];
        ang2_reg <= ang1_reg;
        rem_reg  <= ang_shift - qp_reg;
        red_reg  <= rem_fix[FRAC_BITS +: rk4us_pkg::ANG_W];
        fold_reg <= (red_reg > rk4us_pkg::PI_Q30) ? red_reg - rk4us_pkg::TWO_PI_Q30
                                                  : red_reg;
        cx_reg[0] <= rk4us_pkg::CORDIC_K_Q30;
        cy_reg[0] <= '0;
        priority if (fold_reg > rk4us_pkg::HALF_PI_Q30)
        begin
            cz_reg[0]  <= fold_reg - rk4us_pkg::PI_Q30;
            neg_reg[0] <= 1'b1;
        end
        else if (fold_reg < -rk4us_pkg::HALF_PI_Q30)
        begin
            cz_reg[0]  <= fold_reg + rk4us_pkg::PI_Q30;
            neg_reg[0] <= 1'b1;
        end
        else
        begin
            cz_reg[0]  <= fold_reg;
            neg_reg[0] <= 1'b0;
        end
        for (int i = 0; i < TRIG_STEPS; i++)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (cz_reg[i] >= 0)
            begin
                cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] - rk4us_pkg::ang_t'(rk4us_pkg::ATAN_Q30[i]);
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] + rk4us_pkg::ang_t'(rk4us_pkg::ATAN_Q30[i]);
            end
        end
    end

    assign spd   = line_reg[LAT-3][SIDE_W +: 32];
    assign rnd_c = (pc_reg + 66'sd536870912) >>> 30;
    assign rnd_s = (ps_reg + 66'sd536870912) >>> 30;

    always_ff @(posedge clk)
    begin
        cos_reg <= neg_reg[TRIG_STEPS] ? -cx_reg[TRIG_STEPS] : cx_reg[TRIG_STEPS];
        sin_reg <= neg_reg[TRIG_STEPS] ? -cy_reg[TRIG_STEPS] : cy_reg[TRIG_STEPS];
        pc_reg  <= spd * cos_reg;
        ps_reg  <= spd * sin_reg;
        kx_reg  <= rk4us_pkg::sat_word(rnd_c[47:0]);
        ky_reg  <= rk4us_pkg::sat_word(rnd_s[47:0]);
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_kx    = kx_reg;
    assign out_ky    = ky_reg;
    assign out_side  = line_reg[LAT-1][SIDE_W-1:0];

endmodule

>>> src/rk4us_adv.sv
// Stage state: st + round(k * dt >> SHIFT), saturated.
module rk4us_adv #(
    parameter int SHIFT  = 17,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rk4us_pkg::word_t     in_state [4],
    input  rk4us_pkg::word_t     in_slope [4],
    input  rk4us_pkg::dt_t       step_time,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output rk4us_pkg::word_t     out_state [4],
    output logic [SIDE_W-1:0]    out_side
);

    localparam logic signed [48:0] RND = 49'sd1 <<< (SHIFT - 1);

    logic [1:0]         vld_reg;
    logic signed [48:0] prod_reg [4];
    rk4us_pkg::word_t   st_reg [4];
    rk4us_pkg::word_t   ns_reg [4];
    logic [SIDE_W-1:0]  side1_reg;
    logic [SIDE_W-1:0]  side2_reg;
    logic signed [48:0] rs [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            rs[j] = (prod_reg[j] + RND) >>> SHIFT;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            prod_reg[j] <= in_slope[j] * $signed({1'b0, step_time});
            st_reg[j]   <= in_state[j];
            ns_reg[j]   <= rk4us_pkg::sat_word(48'(st_reg[j]) + 48'(rs[j]));
        end
        side1_reg <= in_side;
        side2_reg <= side1_reg;
    end

    assign out_valid = vld_reg[1];
    assign out_state = ns_reg;
    assign out_side  = side2_reg;

endmodule

>>> src/rk4us_lane.sv
// Final update of one component: st + floor((S*dt + 3*2^16) / (6*2^16)).
module rk4us_lane (
    input  logic              clk,
    input  rk4us_pkg::word_t  in_state,
    input  rk4us_pkg::sum_t   in_sum,
    input  rk4us_pkg::dt_t    step_time,
    output rk4us_pkg::word_t  out_next
);

    logic signed [52:0] p_reg;
    logic signed [52:0] m;
    logic signed [52:0] ub;
    logic [36:0]        u_reg;
    logic [17:0]        a;
    logic [35:0]        qa_prod;
    logic [16:0]        qa;
    logic [17:0]        ra_full;
    logic [16:0]        qa_reg;
    logic [20:0]        n2_reg;
    logic [41:0]        qb_prod;
    logic signed [37:0] q;
    logic signed [37:0] q_reg;
    rk4us_pkg::word_t   st1_reg;
    rk4us_pkg::word_t   st2_reg;
    rk4us_pkg::word_t   st3_reg;
    rk4us_pkg::word_t   st4_reg;
    rk4us_pkg::word_t   next_reg;

    // biased by 3*2^35 so the divide by three runs on unsigned digits
    assign m       = (p_reg + 53'sd196608) >>> 17;
    assign ub      = m + 53'sd103079215104;
    assign a       = u_reg[36:19];
    assign qa_prod = a * 18'd174763;
    assign qa      = qa_prod[35:19];
    assign ra_full = a - {qa, 1'b0} - 18'(qa);
    assign qb_prod = n2_reg * 21'd1398102;
    assign q       = $signed({2'b00, qa_reg, 19'd0}) + $signed(38'(qb_prod[41:22]))
                     - 38'sd34359738368;

    always_ff @(posedge clk)
    begin
        p_reg    <= in_sum * $signed({1'b0, step_time});
        st1_reg  <= in_state;
        u_reg    <= ub[36:0];
        st2_reg  <= st1_reg;
        qa_reg   <= qa;
        n2_reg   <= {ra_full[1:0], u_reg[18:0]};
        st3_reg  <= st2_reg;
        q_reg    <= q;
        st4_reg  <= st3_reg;
        next_reg <= rk4us_pkg::sat_word(48'(st4_reg) + 48'(q_reg));
    end

    assign out_next = next_reg;

endmodule

>>> src/rk4_unicycle_state_step_core.sv
// RK4 unicycle state step core.
// A request is taken on a rising clock edge where start is high and busy is
// low; it carries pos_x, pos_y, heading, speed, accel and yaw_rate (signed
// Q16.16). The result next_x, next_y, next_heading, next_speed appears for
// one cycle with done high. A new request may be issued every cycle while
// busy is low; results come back in request order, one per request.
// The pipeline is four slope units in series, each an angle reduction and a
// TRIG_STEPS-stage CORDIC plus a multiply, three stage-update units and the
// five-stage final divide by six.
// The time step is written through cfg_we/cfg_wdata (unsigned Q0.16); the
// user must write it only while no request is in flight, as the block
// itself does not enforce this. Reset sets it to 6554 and flushes the
// pipeline; busy is high during reset and until the first clock edge after
// it, low otherwise. The receiver cannot stall: done is a one-cycle strobe.
module rk4_unicycle_state_step_core #(
    parameter int FRAC_BITS  = 16,
    parameter int TRIG_STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  rk4us_pkg::word_t  pos_x,
    input  rk4us_pkg::word_t  pos_y,
    input  rk4us_pkg::word_t  heading,
    input  rk4us_pkg::word_t  speed,
    input  rk4us_pkg::word_t  accel,
    input  rk4us_pkg::word_t  yaw_rate,
    output logic              done,
    output rk4us_pkg::word_t  next_x,
    output rk4us_pkg::word_t  next_y,
    output rk4us_pkg::word_t  next_heading,
    output rk4us_pkg::word_t  next_speed
);

    localparam int BASE_W = 192;
    localparam int SIDE_W = BASE_W + 2 * rk4us_pkg::SUM_W;
    localparam int SW     = rk4us_pkg::SUM_W;

    rk4us_pkg::dt_t step_time_reg;
    logic           busy_reg;
    logic [4:0]     fin_vld_reg;
    logic           e4_vld;

    function automatic rk4us_pkg::word_t side_word(input logic [BASE_W-1:0] b,
                                                   input int idx);
        return b[BASE_W-1-32*idx -: 32];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= rk4us_pkg::STEP_TIME_RST;
            busy_reg      <= 1'b1;
            fin_vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_time_reg <= cfg_wdata;
            end
            busy_reg    <= 1'b0;
            fin_vld_reg <= {fin_vld_reg[3:0], e4_vld};
        end
    end

    // slope 1
    logic              e1_vld;
    rk4us_pkg::word_t  e1_kx, e1_ky;
    logic [BASE_W-1:0] e1_side;

    rk4us_eval #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS), .SIDE_W(BASE_W)) u_eval1 (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy_reg),
        .in_angle(heading), .in_speed(speed),
        .in_side({pos_x, pos_y, heading, speed, accel, yaw_rate}),
        .out_valid(e1_vld), .out_kx(e1_kx), .out_ky(e1_ky), .out_side(e1_side)
    );

    rk4us_pkg::word_t  st1 [4];
    rk4us_pkg::word_t  k1 [4];
    logic              a1_vld;
    rk4us_pkg::word_t  a1_state [4];
    logic [SIDE_W-1:0] a1_side;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            st1[j] = side_word(e1_side, j);
        end
        k1[0] = e1_kx;
        k1[1] = e1_ky;
        k1[2] = side_word(e1_side, 5);
        k1[3] = side_word(e1_side, 4);
    end

    rk4us_adv #(.SHIFT(17), .SIDE_W(SIDE_W)) u_adv1 (
        .clk(clk), .rst_n(rst_n), .in_valid(e1_vld), .in_state(st1), .in_slope(k1),
        .step_time(step_time_reg),
        .in_side({e1_side, rk4us_pkg::sum_t'(e1_kx), rk4us_pkg::sum_t'(e1_ky)}),
        .out_valid(a1_vld), .out_state(a1_state), .out_side(a1_side)
    );

    // slope 2
    logic              e2_vld;
    rk4us_pkg::word_t  e2_kx, e2_ky;
    logic [SIDE_W-1:0] e2_side;

    rk4us_eval #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS), .SIDE_W(SIDE_W)) u_eval2 (
        .clk(clk), .rst_n(rst_n), .in_valid(a1_vld),
        .in_angle(a1_state[2]), .in_speed(a1_state[3]), .in_side(a1_side),
        .out_valid(e2_vld), .out_kx(e2_kx), .out_ky(e2_ky), .out_side(e2_side)
    );

    logic [BASE_W-1:0] b2;
    rk4us_pkg::sum_t   sx2_in, sy2_in, sx2, sy2;
    rk4us_pkg::word_t  st2 [4];
    rk4us_pkg::word_t  k2 [4];
    logic              a2_vld;
    rk4us_pkg::word_t  a2_state [4];
    logic [SIDE_W-1:0] a2_side;

    assign b2     = e2_side[SIDE_W-1 -: BASE_W];
    assign sx2_in = e2_side[2*SW-1 -: SW];
    assign sy2_in = e2_side[SW-1:0];
    assign sx2    = sx2_in + (rk4us_pkg::sum_t'(e2_kx) <<< 1);
    assign sy2    = sy2_in + (rk4us_pkg::sum_t'(e2_ky) <<< 1);

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            st2[j] = side_word(b2, j);
        end
        k2[0] = e2_kx;
        k2[1] = e2_ky;
        k2[2] = side_word(b2, 5);
        k2[3] = side_word(b2, 4);
    end

    rk4us_adv #(.SHIFT(17), .SIDE_W(SIDE_W)) u_adv2 (
        .clk(clk), .rst_n(rst_n), .in_valid(e2_vld), .in_state(st2), .in_slope(k2),
        .step_time(step_time_reg), .in_side({b2, sx2, sy2}),
        .out_valid(a2_vld), .out_state(a2_state), .out_side(a2_side)
    );

    // slope 3
    logic              e3_vld;
    rk4us_pkg::word_t  e3_kx, e3_ky;
    logic [SIDE_W-1:0] e3_side;

    rk4us_eval #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS), .SIDE_W(SIDE_W)) u_eval3 (
        .clk(clk), .rst_n(rst_n), .in_valid(a2_vld),
        .in_angle(a2_state[2]), .in_speed(a2_state[3]), .in_side(a2_side),
        .out_valid(e3_vld), .out_kx(e3_kx), .out_ky(e3_ky), .out_side(e3_side)
    );

    logic [BASE_W-1:0] b3;
    rk4us_pkg::sum_t   sx3_in, sy3_in, sx3, sy3;
    rk4us_pkg::word_t  st3 [4];
    rk4us_pkg::word_t  k3 [4];
    logic              a3_vld;
    rk4us_pkg::word_t  a3_state [4];
    logic [SIDE_W-1:0] a3_side;

    assign b3     = e3_side[SIDE_W-1 -: BASE_W];
    assign sx3_in = e3_side[2*SW-1 -: SW];
    assign sy3_in = e3_side[SW-1:0];
    assign sx3    = sx3_in + (rk4us_pkg::sum_t'(e3_kx) <<< 1);
    assign sy3    = sy3_in + (rk4us_pkg::sum_t'(e3_ky) <<< 1);

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            st3[j] = side_word(b3, j);
        end
        k3[0] = e3_kx;
        k3[1] = e3_ky;
        k3[2] = side_word(b3, 5);
        k3[3] = side_word(b3, 4);
    end

    rk4us_adv #(.SHIFT(16), .SIDE_W(SIDE_W)) u_adv3 (
        .clk(clk), .rst_n(rst_n), .in_valid(e3_vld), .in_state(st3), .in_slope(k3),
        .step_time(step_time_reg), .in_side({b3, sx3, sy3}),
        .out_valid(a3_vld), .out_state(a3_state), .out_side(a3_side)
    );

    // slope 4
    rk4us_pkg::word_t  e4_kx, e4_ky;
    logic [SIDE_W-1:0] e4_side;

    rk4us_eval #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS), .SIDE_W(SIDE_W)) u_eval4 (
        .clk(clk), .rst_n(rst_n), .in_valid(a3_vld),
        .in_angle(a3_state[2]), .in_speed(a3_state[3]), .in_side(a3_side),
        .out_valid(e4_vld), .out_kx(e4_kx), .out_ky(e4_ky), .out_side(e4_side)
    );

    logic [BASE_W-1:0] b4;
    rk4us_pkg::sum_t   sx4_in, sy4_in, sx4, sy4;
    rk4us_pkg::sum_t   w4, a4, sth4, sv4;

    assign b4     = e4_side[SIDE_W-1 -: BASE_W];
    assign sx4_in = e4_side[2*SW-1 -: SW];
    assign sy4_in = e4_side[SW-1:0];
    assign sx4    = sx4_in + rk4us_pkg::sum_t'(e4_kx);
    assign sy4    = sy4_in + rk4us_pkg::sum_t'(e4_ky);
    // heading and speed slopes are constant: sum is 6*w and 6*a
    assign w4     = rk4us_pkg::sum_t'(side_word(b4, 5));
    assign a4     = rk4us_pkg::sum_t'(side_word(b4, 4));
    assign sth4   = (w4 <<< 2) + (w4 <<< 1);
    assign sv4    = (a4 <<< 2) + (a4 <<< 1);

    rk4us_lane u_lane_x (
        .clk(clk), .in_state(side_word(b4, 0)), .in_sum(sx4),
        .step_time(step_time_reg), .out_next(next_x)
    );

    rk4us_lane u_lane_y (
        .clk(clk), .in_state(side_word(b4, 1)), .in_sum(sy4),
        .step_time(step_time_reg), .out_next(next_y)
    );

    rk4us_lane u_lane_th (
        .clk(clk), .in_state(side_word(b4, 2)), .in_sum(sth4),
        .step_time(step_time_reg), .out_next(next_heading)
    );

    rk4us_lane u_lane_v (
        .clk(clk), .in_state(side_word(b4, 3)), .in_sum(sv4),
        .step_time(step_time_reg), .out_next(next_speed)
    );

    assign busy = busy_reg;
    assign done = fin_vld_reg[4];

endmodule

>>> src/rk4us_chk.sv
`include "rk4_unicycle_state_step_core_assert.svh"

module rk4us_chk #(
    parameter int LATENCY = 111
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    `RK4US_ASSERT_IMP(a_busy_clears, clk, rst_n, $past(rst_n), !busy)
    `RK4US_ASSERT_NEXT(a_busy_stays_low, clk, rst_n, !busy, !busy)
    `RK4US_ASSERT_IMP(a_done_has_request, clk, rst_n, done, $past(start && !busy, LATENCY))

endmodule

bind rk4_unicycle_state_step_core rk4us_chk #(.LATENCY(4 * TRIG_STEPS + 47)) u_rk4us_chk (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done)
);
